// File: rtl/core/sklst_pkg.sv
// Package for the sorted key list: field widths, action codes and the
// structs that pass between the top level and the storage cells.
// Depends on nothing; every other file imports it.
`default_nettype none

package sklst_pkg;

   localparam int KEY_W    = 32;
   localparam int ACTION_W = 2;
   localparam int OCC_W    = 7;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_LOOKUP = 2'd2
   } action_type;

   // Broadcast to every cell in the cycle an action is taken.
   typedef struct packed {
      logic                    insert_en;
      logic                    remove_en;
      logic signed [KEY_W-1:0] key;
   } cell_cmd_type;

   // What a cell reports about its held key against the broadcast key.
   typedef struct packed {
      logic lt;
      logic eq;
   } cell_status_type;

endpackage

`default_nettype wire

// File: rtl/core/sklst_cell.sv
// One storage cell of the sorted key list chain.
// Holds one key, compares it against the broadcast key and shifts with its
// neighbors on insert and remove. Depends on sklst_pkg.
`default_nettype none

module sklst_cell
   import sklst_pkg::*;
(
   input  wire logic                    clock,
   input  wire cell_cmd_type            cmd,
   input  wire logic                    occupied,
   input  wire logic                    left_lt,
   input  wire logic signed [KEY_W-1:0] left_key,
   input  wire logic signed [KEY_W-1:0] right_key,
   output cell_status_type              status,
   output logic signed [KEY_W-1:0]      key_out
);

   logic signed [KEY_W-1:0] key_ff;
   logic signed [KEY_W-1:0] key_in;

   assign status.lt = occupied && (key_ff < cmd.key);
   assign status.eq = occupied && (key_ff == cmd.key);
   assign key_out   = key_ff;

   // On insert, cells below the insertion point keep their key, the cell at
   // the point takes the new key, and cells above take their left neighbor.
   // On remove, every cell from the removed entry upward takes its right
   // neighbor.
   always_comb begin
      key_in = key_ff;
      if (cmd.insert_en) begin
         if (status.lt) begin
            key_in = key_ff;
         end else if (left_lt) begin
            key_in = cmd.key;
         end else begin
            key_in = left_key;
         end
      end else if (cmd.remove_en) begin
         if (!status.lt) begin
            key_in = right_key;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

`default_nettype wire

// File: rtl/core/sorted_key_list.sv
// Sorted key list: the result of an input transfer is registered and shows in the cycle after it.
// Throughput is one action per cycle while the result side does not stall, set by the
// combinational compare and shift across the cell chain plus the registered result stage.
// Reset (synchronous, active high) empties the list and clears the result
// valid; the cells' keys are not cleared, since occupancy masks them.
// Depends on sklst_pkg and sklst_cell.
`default_nettype none

module sorted_key_list
   import sklst_pkg::*;
#(
   parameter int unsigned CAPACITY = 64
)
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [ACTION_W-1:0]     req_action,
   input  wire logic signed [KEY_W-1:0] req_key,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic                         rsp_ok,
   output logic                         rsp_full_reject,
   output logic [OCC_W-1:0]             rsp_occupancy
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   // The list lives in a chain of cells, cell 0 holding the smallest key.
   // Cell i is occupied exactly when i is below the entry count, so the
   // cells need no valid bits of their own.
   logic [CNT_W-1:0]           count_ff;
   logic [CNT_W-1:0]           count_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic                       rsp_ok_ff;
   logic                       rsp_ok_in;
   logic                       rsp_full_reject_ff;
   logic                       rsp_full_reject_in;
   logic [OCC_W-1:0]           rsp_occupancy_ff;
   logic [OCC_W-1:0]           rsp_occupancy_in;

   logic                       req_accept;
   action_type                 action;
   logic                       is_insert;
   logic                       is_remove;
   logic                       is_lookup;
   logic                       full;
   logic                       found;
   cell_cmd_type               cmd;
   logic [CNT_W+OCC_W-1:0]     count_wide;

   logic signed [KEY_W-1:0]    cell_key [CAPACITY];
   cell_status_type            cell_status [CAPACITY];
   logic [CAPACITY-1:0]        eq_vec;

   // A new transfer is taken unless a finished result is still held back.
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign action     = action_type'(req_action);

   always_comb begin
      is_insert = 1'b0;
      is_remove = 1'b0;
      is_lookup = 1'b0;
      unique case (action)
         ACT_INSERT: is_insert = 1'b1;
         ACT_REMOVE: is_remove = 1'b1;
         ACT_LOOKUP: is_lookup = 1'b1;
         default: ;
      endcase
   end

   assign full  = (count_ff == CNT_W'(CAPACITY));
   assign found = |eq_vec;

   // Insert goes ahead only with room left; remove only when the key is
   // held. Because the list is sorted, the first cell not below the key is
   // where an insert lands and where a matching remove begins.
   assign cmd.insert_en = req_accept && is_insert && !full;
   assign cmd.remove_en = req_accept && is_remove && found;
   assign cmd.key       = req_key;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
      logic                    occupied;
      logic                    left_lt;
      logic signed [KEY_W-1:0] left_key;
      logic signed [KEY_W-1:0] right_key;

      assign occupied = (IDX < count_ff);

      if (i == 0) begin : g_first
         assign left_lt  = 1'b1;
         assign left_key = req_key;
      end else begin : g_inner
         assign left_lt  = cell_status[i-1].lt;
         assign left_key = cell_key[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_key = cell_key[i];
      end else begin : g_body
         assign right_key = cell_key[i+1];
      end

      sklst_cell u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .occupied  (occupied),
         .left_lt   (left_lt),
         .left_key  (left_key),
         .right_key (right_key),
         .status    (cell_status[i]),
         .key_out   (cell_key[i])
      );

      assign eq_vec[i] = cell_status[i].eq;
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.insert_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.remove_en) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // The reported occupancy is the new count cut to the field width.
   assign count_wide = (CNT_W+OCC_W)'(count_in);

   always_comb begin
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_ok_in          = rsp_ok_ff;
      rsp_full_reject_in = rsp_full_reject_ff;
      rsp_occupancy_in   = rsp_occupancy_ff;
      if (req_accept) begin
         rsp_valid_in       = 1'b1;
         rsp_ok_in          = cmd.insert_en || ((is_remove || is_lookup) && found);
         rsp_full_reject_in = is_insert && full;
         rsp_occupancy_in   = count_wide[OCC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ok_ff          <= rsp_ok_in;
      rsp_full_reject_ff <= rsp_full_reject_in;
      rsp_occupancy_ff   <= rsp_occupancy_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_full_reject = rsp_full_reject_ff;
   assign rsp_occupancy   = rsp_occupancy_ff;

`ifndef SYNTH
   // The count can never pass the number of cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   // An insert into a full list is refused and flagged.
   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      req_accept && is_insert && full |=> rsp_full_reject_ff && !rsp_ok_ff)
      else $error("insert into full list not refused");

   // A result never claims success and refusal together.
   a_ok_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ok_ff && rsp_full_reject_ff))
      else $error("ok and full reject both set");

   // A completed insert grows the list by exactly one entry.
   a_insert_grow: assert property (@(posedge clock) disable iff (reset)
      cmd.insert_en |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not add one entry");

   // Lookups and unused action codes leave the count alone.
   a_lookup_stable: assert property (@(posedge clock) disable iff (reset)
      req_accept && !is_insert && !is_remove |=> $stable(count_ff))
      else $error("count changed on lookup");
`endif

endmodule

`default_nettype wire

// File: tb/sorted_key_list_tb.sv
// Self-checking testbench for sorted_key_list: a directed table, then random
// insert/remove/lookup traffic with random idling on both channels.
// Depends on sklst_pkg and the sorted_key_list RTL.
`timescale 1ns / 1ps

module sorted_key_list_tb;
   import sklst_pkg::*;

   localparam int unsigned LIST_DEPTH     = 64;
   localparam int          RANDOM_ITEMS   = 1800;
   localparam int          QUIET_ITEMS    = 200;
   localparam int          WATCHDOG_LIMIT = 1000;
   localparam int          DRAIN_CYCLES   = 4;

   // The action code that the package leaves unused; the block treats it as a no-op.
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

   typedef struct packed {
      logic             ok;
      logic             full_reject;
      logic [OCC_W-1:0] occupancy;
   } list_answer_type;

   typedef struct {
      logic [ACTION_W-1:0]     action;
      logic signed [KEY_W-1:0] key;
      bit                      typed;
      list_answer_type         answer;
   } table_row_type;

   typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_mode_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [ACTION_W-1:0]     req_action;
   logic signed [KEY_W-1:0] req_key;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic                    rsp_ok;
   logic                    rsp_full_reject;
   logic [OCC_W-1:0]        rsp_occupancy;

   // A typed answer travels with the transfer and replaces the predicted one.
   bit              item_typed;
   list_answer_type item_answer;

   logic signed [KEY_W-1:0] held_keys[$];
   list_answer_type         pending_answers[$];
   logic signed [KEY_W-1:0] key_pool[16];

   int  error_count;
   int  idle_cycles;
   int  stall_left;
   int  stall_rate;
   int  gap_rate;
   bit  quiet_tail;
   int  n_items;
   int  n_inserted;
   int  n_rejected;
   int  n_removed;
   int  n_found;
   int  peak_occupancy;

   sorted_key_list #(.CAPACITY(LIST_DEPTH)) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_ok          (rsp_ok),
      .rsp_full_reject (rsp_full_reject),
      .rsp_occupancy   (rsp_occupancy)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Sorted-list predictor. Inserts go in front of equal keys, removes take the
   // first equal key, and a full list refuses an insert without changing.
   function automatic list_answer_type apply_action(input logic [ACTION_W-1:0] act,
                                                    input logic signed [KEY_W-1:0] k);
      list_answer_type res;
      int              pos;
      res = '0;
      pos = 0;
      case (act)
         ACT_INSERT: begin
            if (held_keys.size() >= LIST_DEPTH) begin
               res.full_reject = 1'b1;
            end else begin
               while (pos < held_keys.size() && held_keys[pos] < k) pos++;
               held_keys.insert(pos, k);
               res.ok = 1'b1;
            end
         end
         ACT_REMOVE: begin
            while (pos < held_keys.size() && held_keys[pos] != k) pos++;
            if (pos < held_keys.size()) begin
               held_keys.delete(pos);
               res.ok = 1'b1;
            end
         end
         ACT_LOOKUP: begin
            while (pos < held_keys.size() && held_keys[pos] != k) pos++;
            res.ok = (pos < held_keys.size());
         end
         default: ;
      endcase
      res.occupancy = OCC_W'(held_keys.size());
      return res;
   endfunction

   // Transfers are sampled at the rising edge, where every signal still holds
   // the value it had before the edge.
   always @(posedge clock) begin
      list_answer_type want;
      list_answer_type got;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;

         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_ok, rsp_full_reject, rsp_occupancy};
            if (pending_answers.size() == 0) begin
               $error("result with no expectation: ok=%0d full_reject=%0d occupancy=%0d",
                      got.ok, got.full_reject, got.occupancy);
               error_count++;
            end else begin
               want = pending_answers.pop_front();
               if (got.ok !== want.ok) begin
                  $error("ok: expected %0d, got %0d", want.ok, got.ok);
                  error_count++;
               end
               if (got.full_reject !== want.full_reject) begin
                  $error("full_reject: expected %0d, got %0d",
                         want.full_reject, got.full_reject);
                  error_count++;
               end
               if (got.occupancy !== want.occupancy) begin
                  $error("occupancy: expected %0d, got %0d",
                         want.occupancy, got.occupancy);
                  error_count++;
               end
            end
         end

         if (req_valid && !req_stall) begin
            want = apply_action(req_action, req_key);
            if (item_typed) want = item_answer;
            pending_answers.push_back(want);
            n_items++;
            if (req_action == ACT_INSERT && want.ok) n_inserted++;
            if (want.full_reject) n_rejected++;
            if (req_action == ACT_REMOVE && want.ok) n_removed++;
            if (req_action == ACT_LOOKUP && want.ok) n_found++;
            if (int'(want.occupancy) > peak_occupancy) peak_occupancy = int'(want.occupancy);
         end
      end
   end

   // Result-side stall comes in bursts, started at a rate the
   // stimulus sets per phase; a rate of zero gives a stretch with no stalls.
   always @(negedge clock) begin
      if (reset || quiet_tail || stall_rate == 0) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(1, stall_rate) == 1) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 16);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_action(input logic [ACTION_W-1:0] act,
                              input logic signed [KEY_W-1:0] k,
                              input bit typed,
                              input list_answer_type answer);
      int gap;
      if (!quiet_tail && gap_rate != 0 && $urandom_range(1, gap_rate) == 1) begin
         gap = $urandom_range(1, 17);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= act;
      req_key     <= k;
      item_typed  <= typed;
      item_answer <= answer;
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
   endtask

   // Mostly keys already held or from a small pool so that removes and
   // lookups hit; the rest are extremes or fully random patterns.
   function automatic logic signed [KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4 && held_keys.size() != 0)
         return held_keys[$urandom_range(0, held_keys.size() - 1)];
      else if (r < 7)
         return key_pool[$urandom_range(0, 15)];
      else if (r == 7)
         case ($urandom_range(0, 3))
            0: return KEY_MIN;
            1: return KEY_MAX;
            2: return '0;
            default: return -1;
         endcase
      else
         return $urandom();
   endfunction

   function automatic logic [ACTION_W-1:0] pick_action(input traffic_mode_type mode);
      int r;
      int ins_lim;
      int rem_lim;
      r = $urandom_range(0, 99);
      case (mode)
         MODE_FILL:  begin ins_lim = 80; rem_lim = 90; end
         MODE_DRAIN: begin ins_lim = 15; rem_lim = 80; end
         default:    begin ins_lim = 40; rem_lim = 70; end
      endcase
      if (r < ins_lim) return ACT_INSERT;
      else if (r < rem_lim) return ACT_REMOVE;
      else if (r < 97) return ACT_LOOKUP;
      else return ACT_UNUSED;
   endfunction

   initial begin
      table_row_type    directed[$];
      traffic_mode_type mode;
      int               phase_len;
      int               sent;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_action  = ACT_INSERT;
      req_key     = '0;
      rsp_stall   = 1'b0;
      item_typed  = 1'b0;
      item_answer = '0;
      error_count = 0;
      idle_cycles = 0;
      stall_left  = 0;
      stall_rate  = 0;
      gap_rate    = 0;
      quiet_tail  = 1'b0;
      n_items = 0; n_inserted = 0; n_rejected = 0; n_removed = 0; n_found = 0;
      peak_occupancy = 0;

      // Directed table: empty-list behavior, the key extremes, duplicates,
      // the unused action code and removal of an absent key.
      directed = '{
         '{ACT_LOOKUP, 32'sd0,          1'b1, '{1'b0, 1'b0, 7'd0}},
         '{ACT_REMOVE, 32'sd5,          1'b1, '{1'b0, 1'b0, 7'd0}},
         '{ACT_UNUSED, -32'sd1,         1'b1, '{1'b0, 1'b0, 7'd0}},
         '{ACT_INSERT, KEY_MIN,         1'b1, '{1'b1, 1'b0, 7'd1}},
         '{ACT_INSERT, KEY_MAX,         1'b1, '{1'b1, 1'b0, 7'd2}},
         '{ACT_INSERT, 32'sd0,          1'b1, '{1'b1, 1'b0, 7'd3}},
         '{ACT_INSERT, -32'sd1,         1'b1, '{1'b1, 1'b0, 7'd4}},
         '{ACT_INSERT, -32'sd1,         1'b1, '{1'b1, 1'b0, 7'd5}},
         '{ACT_INSERT, 32'sd1,          1'b1, '{1'b1, 1'b0, 7'd6}},
         '{ACT_LOOKUP, KEY_MIN,         1'b1, '{1'b1, 1'b0, 7'd6}},
         '{ACT_LOOKUP, KEY_MAX,         1'b1, '{1'b1, 1'b0, 7'd6}},
         '{ACT_LOOKUP, 32'sd2,          1'b1, '{1'b0, 1'b0, 7'd6}},
         '{ACT_LOOKUP, -32'sd2,         1'b0, '0},
         '{ACT_REMOVE, -32'sd1,         1'b1, '{1'b1, 1'b0, 7'd5}},
         '{ACT_LOOKUP, -32'sd1,         1'b1, '{1'b1, 1'b0, 7'd5}},
         '{ACT_REMOVE, -32'sd1,         1'b1, '{1'b1, 1'b0, 7'd4}},
         '{ACT_REMOVE, -32'sd1,         1'b1, '{1'b0, 1'b0, 7'd4}},
         '{ACT_UNUSED, 32'sd0,          1'b1, '{1'b0, 1'b0, 7'd4}},
         '{ACT_REMOVE, KEY_MIN,         1'b1, '{1'b1, 1'b0, 7'd3}},
         '{ACT_INSERT, 32'sh5555_5555,  1'b0, '0},
         '{ACT_INSERT, 32'shaaaa_aaaa,  1'b0, '0},
         '{ACT_LOOKUP, 32'shaaaa_aaaa,  1'b0, '0},
         '{ACT_REMOVE, KEY_MAX,         1'b0, '0},
         '{ACT_LOOKUP, 32'sh5555_5555,  1'b0, '0}
      };

      foreach (key_pool[i]) key_pool[i] = $urandom();

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed[i])
         send_action(directed[i].action, directed[i].key,
                     directed[i].typed, directed[i].answer);

      // Random phases. The first is insert-heavy so the list can fill and then
      // refuse inserts; later phases pick at random among filling, draining
      // and mixed traffic with varying amounts of idling.
      sent = 0;
      mode = MODE_FILL;
      while (sent < RANDOM_ITEMS) begin
         phase_len  = $urandom_range(60, 140);
         stall_rate = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(2, 12);
         gap_rate   = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(2, 12);
         for (int j = 0; j < phase_len && sent < RANDOM_ITEMS; j++) begin
            quiet_tail = (sent >= RANDOM_ITEMS - QUIET_ITEMS);
            send_action(pick_action(mode), pick_key(), 1'b0, '0);
            sent++;
         end
         mode = traffic_mode_type'($urandom_range(0, 2));
      end

      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d actions: %0d inserts, %0d refused on a full list,",
               n_items, n_inserted, n_rejected);
      $display("%0d removes and %0d lookups that hit; peak occupancy %0d of %0d.",
               n_removed, n_found, peak_occupancy, LIST_DEPTH);
      if (error_count == 0 && pending_answers.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
